@@ src/indexed_insert_remove_list_defines.svh @@
// Assertion macros shared by the list RTL.
`ifndef INDEXED_INSERT_REMOVE_LIST_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_LIST_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define IIRL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define IIRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define IIRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/iirl_pkg.sv @@
`default_nettype none
package iirl_pkg;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;

endpackage
`default_nettype wire

@@ src/iirl_ram.sv @@
`default_nettype none
module iirl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Simple dual-port storage with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ src/indexed_insert_remove_list.sv @@
// Order: append, insert at the end, error and unused commands give their result in the
// cycle after acceptance; read and remove-last pass through the registered RAM read and
// the WAIT state; remove at index walks SHIFT, and insert at index walks SHIFT, then FILL.
// Throughput: busy stays high until the result strobe, so the next transaction follows it;
// the shift rate is one word per cycle, set by the single read and write port of the RAM.
// Reset (synchronous, active low) empties the list at once; the receiver cannot stall.
`default_nettype none
`include "indexed_insert_remove_list_defines.svh"
module indexed_insert_remove_list
    import iirl_pkg::*;
#(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned WORD_WIDTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    input  wire logic [CMD_W-1:0]          i_command,
    input  wire logic [INDEX_W-1:0]        i_index,
    input  wire logic signed [VALUE_W-1:0] i_value,
    output logic                           busy,
    output logic                           o_valid,
    output logic signed [VALUE_W-1:0]      o_value_out,
    output logic [COUNT_W-1:0]             o_count,
    output logic                           o_is_empty,
    output logic [1:0]                     o_status
);

    // Address width of the word store, width of the fill count, and a width wide
    // enough to compare the external index against the count without overflow.
    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > INDEX_W + 1) ? CW : INDEX_W + 1;

    // The sequencer walks the list for the shifting commands. WAIT collects a single
    // read, SHIFT moves one word per cycle and FILL drops the new word into its slot.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_SHIFT,
        S_FILL
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_valid, n_valid;
    logic [VALUE_W-1:0]    r_value, n_value;
    t_status               r_status, n_status;
    logic [WORD_WIDTH-1:0] r_word, n_word;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_dat, n_dat;
    logic                  r_more, n_more;
    logic                  r_dn, n_dn;
    logic                  r_pop, n_pop;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_WIDTH-1:0] ram_rdata;

    logic [WORD_WIDTH-1:0] w_word;
    logic [VALUE_W-1:0]    w_rd_ext;
    logic [CMPW-1:0]       w_idx_c;
    logic [CMPW-1:0]       w_cnt_c;
    logic                  w_full;
    logic                  w_empty;
    logic [AW-1:0]         w_last;
    logic [AW-1:0]         w_next;

    iirl_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The incoming word is sign-extended from 32 bits and kept in WORD_WIDTH bits;
    // a word read back is sign-extended from WORD_WIDTH and kept in 32 bits.
    always_comb begin
        for (int i = 0; i < WORD_WIDTH; i++) begin
            w_word[i] = i_value[(i < VALUE_W) ? i : VALUE_W - 1];
        end
        for (int j = 0; j < VALUE_W; j++) begin
            w_rd_ext[j] = ram_rdata[(j < WORD_WIDTH) ? j : WORD_WIDTH - 1];
        end
    end

    assign w_idx_c = CMPW'(i_index);
    assign w_cnt_c = CMPW'(r_count);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_last  = AW'(r_count - CW'(1));
    assign w_next  = r_dn ? (r_dat + AW'(1)) : (r_dat - AW'(1));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_value   = r_value;
        n_status  = r_status;
        n_word    = r_word;
        n_idx     = r_idx;
        n_dat     = r_dat;
        n_more    = r_more;
        n_dn      = r_dn;
        n_pop     = r_pop;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_word;
        ram_re    = 1'b0;
        ram_raddr = r_dat;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_value  = '0;
                    n_status = ST_OK;
                    n_word   = w_word;
                    n_idx    = AW'(i_index);
                    case (t_cmd'(i_command))
                        CMD_APPEND: begin
                            n_valid = 1'b1;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_count);
                                ram_wdata = w_word;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (w_empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = w_last;
                                n_pop     = 1'b1;
                                n_state   = S_WAIT;
                            end
                        end
                        CMD_INSERT: begin
                            if (w_full) begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end else if (w_idx_c > w_cnt_c) begin
                                n_valid  = 1'b1;
                                n_status = ST_RANGE;
                            end else if (w_idx_c == w_cnt_c) begin
                                // Inserting at the end is an append.
                                n_valid   = 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_count);
                                ram_wdata = w_word;
                                n_count   = r_count + CW'(1);
                            end else begin
                                // Walk down from the top entry, moving each word up one.
                                ram_re    = 1'b1;
                                ram_raddr = w_last;
                                n_dat     = w_last;
                                n_more    = (w_cnt_c - CMPW'(1)) > w_idx_c;
                                n_dn      = 1'b0;
                                n_state   = S_SHIFT;
                            end
                        end
                        CMD_REMOVE: begin
                            if (w_empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else if (w_idx_c >= w_cnt_c) begin
                                n_valid  = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                // Walk up from the removed entry, moving each word down one.
                                ram_re    = 1'b1;
                                ram_raddr = AW'(i_index);
                                n_dat     = AW'(i_index);
                                n_more    = (w_idx_c + CMPW'(1)) < w_cnt_c;
                                n_dn      = 1'b1;
                                n_state   = S_SHIFT;
                            end
                        end
                        CMD_READ: begin
                            if (w_empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else if (w_idx_c >= w_cnt_c) begin
                                n_valid  = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = AW'(i_index);
                                n_pop     = 1'b0;
                                n_state   = S_WAIT;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_WAIT: begin
                n_value = w_rd_ext;
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (r_pop) begin
                    n_count = r_count - CW'(1);
                end
            end
            S_SHIFT: begin
                // The word read last cycle either is the removed one or moves one slot.
                if (r_dn && (r_dat == r_idx)) begin
                    n_value = w_rd_ext;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_dn ? (r_dat - AW'(1)) : (r_dat + AW'(1));
                    ram_wdata = ram_rdata;
                end
                if (r_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = w_next;
                    n_dat     = w_next;
                    n_more    = r_dn ? ((CW'(w_next) + CW'(1)) < r_count) : (w_next > r_idx);
                end else if (r_dn) begin
                    n_count = r_count - CW'(1);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = r_word;
                n_count   = r_count + CW'(1);
                n_valid   = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_status <= n_status;
        r_word   <= n_word;
        r_idx    <= n_idx;
        r_dat    <= n_dat;
        r_more   <= n_more;
        r_dn     <= n_dn;
        r_pop    <= n_pop;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // The count register changes only together with a result, so it doubles as the
    // count field of the result.
    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_value_out = r_value;
    assign o_count     = COUNT_W'(r_count);
    assign o_is_empty  = (r_count == '0);
    assign o_status    = r_status;

    `IIRL_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count above depth")
    `IIRL_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, r_valid, r_state == S_IDLE, "result while busy")
    `IIRL_ASSERT_IMP(a_port_clash, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "read and write hit one entry")
    `IIRL_ASSERT_IMP(a_count_with_result, i_clk, i_rst_n, !$stable(r_count), r_valid, "count moved without a result")

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

// Testbench for the indexed insert/remove list. A shadow copy of the list in
// this module predicts every reply. A checker compares each reply strobe with
// the oldest prediction that is still waiting.
module tb_top
    import iirl_pkg::*;
();

    localparam int unsigned LIST_DEPTH = 64;
    localparam int unsigned WORD_BITS  = 32;

    // The worst correct run is about 550 transactions. Each one can wait out
    // a long idle gap and an insert that shifts the whole list. Even so, this
    // limit leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT = 500_000;

    // The largest shift is an insert at index zero into 63 entries. The
    // drain at the end waits a little longer than that.
    localparam int unsigned DRAIN_CYCLES = 80;

    // Command codes above CMD_READ are spare. The block must answer them with
    // an ok status and leave the list alone.
    localparam logic [CMD_W-1:0] FIRST_SPARE_CMD = CMD_W'(CMD_READ + 1);
    localparam logic [CMD_W-1:0] LAST_SPARE_CMD  = '1;

    localparam logic [VALUE_W-1:0] MOST_POSITIVE = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        t_status            status;
    } t_list_reply;

    // Every input is driven from time zero so that nothing reaches the block as X.
    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                start     = 1'b0;
    logic [CMD_W-1:0]    i_command = '0;
    logic [INDEX_W-1:0]  i_index   = '0;
    logic [VALUE_W-1:0]  i_value   = '0;
    logic                busy;
    logic                o_valid;
    logic [VALUE_W-1:0]  o_value_out;
    logic [COUNT_W-1:0]  o_count;
    logic                o_is_empty;
    logic [1:0]          o_status;

    // This is the shadow of the list contents and fill level. It is updated
    // once for each accepted transaction, in the order of acceptance.
    logic [WORD_BITS-1:0] shadow_words [LIST_DEPTH] = '{default: '0};
    int unsigned          shadow_count = 0;

    t_list_reply awaited_replies [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // While this is set, the sender never idles. The list is then filled
    // back to back.
    bit steady_traffic = 1'b0;

    indexed_insert_remove_list #(
        .DEPTH      (LIST_DEPTH),
        .WORD_WIDTH (WORD_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_command   (i_command),
        .i_index     (i_index),
        .i_value     (i_value),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_value_out (o_value_out),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .o_status    (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // This runs one command against the shadow list and returns the reply
    // that the block must give. An error or a spare code leaves the shadow
    // untouched.
    function automatic t_list_reply shadow_execute(input logic [CMD_W-1:0] cmd,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic [VALUE_W-1:0] val);
        t_list_reply reply;
        int unsigned at;
        int unsigned k;
        at = 32'(idx);
        reply.value  = '0;
        reply.status = ST_OK;
        case (cmd)
            CMD_APPEND: begin
                if (shadow_count >= LIST_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    shadow_words[shadow_count] = WORD_BITS'($signed(val));
                    shadow_count++;
                end
            end
            CMD_POP: begin
                if (shadow_count == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                    reply.value = VALUE_W'($signed(shadow_words[shadow_count]));
                    shadow_words[shadow_count] = '0;
                end
            end
            CMD_INSERT: begin
                // A full list is reported before the index is looked at.
                if (shadow_count >= LIST_DEPTH) begin
                    reply.status = ST_FULL;
                end else if (at > shadow_count) begin
                    reply.status = ST_RANGE;
                end else begin
                    for (k = shadow_count; k > at; k--) begin
                        shadow_words[k] = shadow_words[k-1];
                    end
                    shadow_words[at] = WORD_BITS'($signed(val));
                    shadow_count++;
                end
            end
            CMD_REMOVE: begin
                if (shadow_count == 0) begin
                    reply.status = ST_EMPTY;
                end else if (at >= shadow_count) begin
                    reply.status = ST_RANGE;
                end else begin
                    reply.value = VALUE_W'($signed(shadow_words[at]));
                    for (k = at; k + 1 < shadow_count; k++) begin
                        shadow_words[k] = shadow_words[k+1];
                    end
                    shadow_count--;
                    shadow_words[shadow_count] = '0;
                end
            end
            CMD_READ: begin
                if (shadow_count == 0) begin
                    reply.status = ST_EMPTY;
                end else if (at >= shadow_count) begin
                    reply.status = ST_RANGE;
                end else begin
                    reply.value = VALUE_W'($signed(shadow_words[at]));
                end
            end
            default: begin
            end
        endcase
        reply.count    = COUNT_W'(shadow_count);
        reply.is_empty = (shadow_count == 0);
        return reply;
    endfunction

    // This sends one transaction. Start stays high until an edge finds busy
    // low. At that edge the command is taken, so its reply is predicted then.
    // After that the sender may idle for a while with noise on the fields. If
    // it does not idle, start stays high for the next call.
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic [INDEX_W-1:0] idx,
                                 input logic [VALUE_W-1:0] val);
        start     <= 1'b1;
        i_command <= cmd;
        i_index   <= idx;
        i_value   <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        awaited_replies.insert(awaited_replies.size(), shadow_execute(cmd, idx, val));
        if (!steady_traffic && $urandom_range(99) < 27) begin
            start     <= 1'b0;
            i_command <= CMD_W'($urandom);
            i_index   <= INDEX_W'($urandom);
            i_value   <= $urandom;
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // This picks a word with extra weight on the sign boundary, on zero and on all ones.
    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(19))
            0:       return MOST_POSITIVE;
            1:       return MOST_NEGATIVE;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // This picks an index that is legal for the command and the current fill
    // level. Now and then it picks any index, which may lie past the end.
    function automatic logic [INDEX_W-1:0] pick_index(input logic [CMD_W-1:0] cmd);
        int unsigned last_slot;
        if ($urandom_range(99) < 8) begin
            return INDEX_W'($urandom);
        end
        if (cmd == CMD_INSERT) begin
            last_slot = (shadow_count < LIST_DEPTH) ? shadow_count : LIST_DEPTH - 1;
            return INDEX_W'($urandom_range(last_slot));
        end
        if (shadow_count == 0) begin
            return INDEX_W'($urandom);
        end
        return INDEX_W'($urandom_range(shadow_count - 1));
    endfunction

    // The list starts empty. Every removal and read must report empty, and
    // each spare code must be ignored.
    task automatic test_empty_list();
        logic [CMD_W-1:0] spare;
        issue_command(CMD_POP, '0, '0);
        issue_command(CMD_REMOVE, '0, '0);
        issue_command(CMD_READ, '1, '0);
        for (spare = FIRST_SPARE_CMD; spare != '0; spare++) begin
            issue_command(spare, INDEX_W'($urandom), $urandom);
        end
    endtask

    // These are short directed checks: words on the sign boundary, insertion
    // at the front and at the end, and indexes one past the end for insert,
    // read and remove. A pop of the last entry takes the list back to empty.
    task automatic test_list_boundaries();
        issue_command(CMD_APPEND, '0, MOST_POSITIVE);
        issue_command(CMD_APPEND, '1, MOST_NEGATIVE);
        issue_command(CMD_INSERT, '0, '1);
        issue_command(CMD_INSERT, INDEX_W'(shadow_count), 32'h0000_5A5A);
        issue_command(CMD_INSERT, INDEX_W'(shadow_count + 1), $urandom);
        issue_command(CMD_READ, '0, '0);
        issue_command(CMD_READ, INDEX_W'(shadow_count - 1), '0);
        issue_command(CMD_READ, INDEX_W'(shadow_count), '0);
        issue_command(CMD_REMOVE, INDEX_W'(shadow_count), '0);
        issue_command(CMD_REMOVE, 6'd1, '0);
        while (shadow_count != 0) begin
            issue_command(CMD_POP, INDEX_W'($urandom), $urandom);
        end
        issue_command(CMD_POP, '0, '0);
    endtask

    // The list is filled to the top back to back, with no idle cycles. Then
    // append and insert must report full, whatever the index. The longest
    // shifts are run, and the list is drained with removals at random places.
    task automatic test_full_list();
        steady_traffic = 1'b1;
        while (shadow_count < LIST_DEPTH) begin
            issue_command(CMD_APPEND, INDEX_W'($urandom), pick_word());
        end
        steady_traffic = 1'b0;
        issue_command(CMD_APPEND, '0, $urandom);
        issue_command(CMD_INSERT, '0, $urandom);
        issue_command(CMD_INSERT, '1, $urandom);
        issue_command(CMD_READ, '1, '0);
        issue_command(CMD_READ, '0, '0);
        issue_command(CMD_REMOVE, '1, '0);
        // At 63 entries, index 63 is the end of the list. The insert at
        // index zero then moves every entry.
        issue_command(CMD_INSERT, '1, pick_word());
        issue_command(CMD_REMOVE, '0, '0);
        issue_command(CMD_INSERT, '0, pick_word());
        while (shadow_count != 0) begin
            if ($urandom_range(1) == 0) begin
                issue_command(CMD_POP, INDEX_W'($urandom), $urandom);
            end else begin
                issue_command(CMD_REMOVE, pick_index(CMD_REMOVE), $urandom);
            end
        end
        issue_command(CMD_REMOVE, '1, '0);
    endtask

    // This is mixed traffic that follows a target fill level. The target
    // moves every few dozen transactions, often to empty or full, so the
    // list keeps rising and falling across its whole range. Reads, spare
    // codes and out-of-range indexes are mixed in.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned      tide;
        int unsigned      roll;
        bit               growing;
        logic [CMD_W-1:0] cmd;
        tide = LIST_DEPTH / 2;
        for (int unsigned n = 0; n < n_items; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(3))
                    0:       tide = 0;
                    1:       tide = LIST_DEPTH;
                    default: tide = $urandom_range(LIST_DEPTH);
                endcase
            end
            growing = (shadow_count < tide);
            roll    = $urandom_range(99);
            if (roll < 5) begin
                cmd = CMD_W'($urandom_range(FIRST_SPARE_CMD, LAST_SPARE_CMD));
            end else if (roll < 20) begin
                cmd = CMD_READ;
            end else if ($urandom_range(99) < (growing ? 75 : 25)) begin
                cmd = ($urandom_range(1) == 0) ? CMD_APPEND : CMD_INSERT;
            end else begin
                cmd = ($urandom_range(1) == 0) ? CMD_POP : CMD_REMOVE;
            end
            issue_command(cmd, pick_index(cmd), pick_word());
        end
    endtask

    // The checker works at every clock edge. A strobe marks a reply that is
    // taken at that edge. It is compared field by field with the oldest
    // prediction. A strobe with nothing waiting is an error too.
    task automatic compare_field(input string field, input logic [VALUE_W-1:0] want_v,
                                 input logic [VALUE_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_replies
        t_list_reply want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t: stray reply, expected nothing, actual %h count %0d status %0d",
                         $time, o_value_out, o_count, o_status);
                mismatch_count++;
            end else begin
                want = awaited_replies.pop_front();
                compare_field("value_out", want.value, o_value_out);
                compare_field("count", VALUE_W'(want.count), VALUE_W'(o_count));
                compare_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(o_is_empty));
                compare_field("status", VALUE_W'(want.status), VALUE_W'(o_status));
            end
        end
    end

    // This is the watchdog. A stalled handshake or a lost reply ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_list_boundaries();
        test_full_list();
        test_random_traffic(350);

        start <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        // The drain catches any stray reply strobe after the last one
        // that was expected.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
